/* rtl/core/mtcp_pkg.sv */
// ----------------------------------------------------------------------------
// mtcp_pkg
// Types and constants for the serial tone command port.
// ----------------------------------------------------------------------------
package mtcp_pkg;

    // request kinds
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // register offsets
    localparam logic [7:0] OFS_DATA_HI = 8'h22;
    localparam logic [7:0] OFS_DATA_LO = 8'h23;
    localparam logic [7:0] OFS_MASK_HI = 8'h24;
    localparam logic [7:0] OFS_MASK_LO = 8'h25;

    localparam logic [7:0] READ_UNMAPPED = 8'hFF;

    // command selectors
    localparam logic [2:0] SEL_MIX    = 3'd0;
    localparam logic [2:0] SEL_BASS   = 3'd1;
    localparam logic [2:0] SEL_TREBLE = 3'd2;
    localparam logic [2:0] SEL_MASTER = 3'd3;
    localparam logic [2:0] SEL_RIGHT  = 3'd4;
    localparam logic [2:0] SEL_LEFT   = 3'd5;

    localparam int          MIN_RUN    = 11;
    localparam logic [4:0]  STEPS_FULL = 5'd16;

    // cold reset settings, 0 dB and flat tone
    localparam logic [1:0] MIX_RST    = 2'd0;
    localparam logic [3:0] TONE_RST   = 4'd6;
    localparam logic [5:0] MASTER_RST = 6'd40;
    localparam logic [4:0] SIDE_RST   = 5'd20;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] reg_offset;
        logic [7:0] write_data;
    } mtcp_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       busy_res;
        logic [1:0] mix_select;
        logic [3:0] bass_code;
        logic [3:0] treble_code;
        logic [5:0] master_volume;
        logic [4:0] left_volume;
        logic [4:0] right_volume;
    } mtcp_rsp_t;

endpackage

/* rtl/core/microwire_tone_command_port.sv */
// ----------------------------------------------------------------------------
// microwire_tone_command_port
// Byte register port with a 16-step serial transfer that decodes tone and
// volume commands from the masked data word.
// ----------------------------------------------------------------------------
// a transaction goes into the input register, then into the result register
// throughput: one transaction per cycle unless m_ready stalls the result,
// set by both registers; run scan and command decode are combinational between
// reset: synchronous active-low aresetn clears both stages and the transfer,
// settings return to mix 0, flat tone (6), master 40, left and right 20
module microwire_tone_command_port
    import mtcp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mtcp_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mtcp_rsp_t m_data
);

    logic       in_valid_reg;
    mtcp_req_t  in_data_reg;
    logic       out_valid_reg;
    mtcp_rsp_t  out_data_reg;
    logic       advance;

    logic [15:0] data_word_reg,  data_word_next;
    logic [15:0] mask_word_reg,  mask_word_next;
    logic [15:0] shift_word_reg, shift_word_next;
    logic [4:0]  steps_left_reg, steps_left_next;
    logic [1:0]  mix_reg,    mix_next;
    logic [3:0]  bass_reg,   bass_next;
    logic [3:0]  treble_reg, treble_next;
    logic [5:0]  master_reg, master_next;
    logic [4:0]  left_reg,   left_next;
    logic [4:0]  right_reg,  right_next;

    logic [7:0]  rd_byte;
    logic [4:0]  shift_amt;
    logic [2:0]  run_lo;
    logic [3:0]  run_hi;
    logic        cmd_ok;
    logic [15:0] cmd_word;
    logic [2:0]  cmd_sel;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a run of 11 or more bits in 16 always covers bits 10..5, so there is
    // at most one and it is the one through bit 5
    always_comb begin
        logic done_lo;
        logic done_hi;
        done_lo = 1'b0;
        done_hi = 1'b0;
        run_lo  = 3'd5;
        run_hi  = 4'd10;
        for (int i = 4; i >= 0; i--) begin
            if (!done_lo && mask_word_reg[i]) begin
                run_lo = 3'(i);
            end else begin
                done_lo = 1'b1;
            end
        end
        for (int j = 11; j <= 15; j++) begin
            if (!done_hi && mask_word_reg[j]) begin
                run_hi = 4'(j);
            end else begin
                done_hi = 1'b1;
            end
        end
    end

    assign cmd_word = data_word_reg >> run_lo;
    assign cmd_sel  = cmd_word[8:6];
    assign cmd_ok   = (&mask_word_reg[10:5])
                   && ((5'(run_hi) - 5'(run_lo) + 5'd1) >= 5'(MIN_RUN))
                   && data_word_reg[run_hi]
                   && !data_word_reg[run_hi - 4'd1];

    always_comb begin
        case (in_data_reg.reg_offset)
            OFS_DATA_HI: rd_byte = shift_word_reg[15:8];
            OFS_DATA_LO: rd_byte = shift_word_reg[7:0];
            OFS_MASK_HI: rd_byte = mask_word_reg[15:8];
            OFS_MASK_LO: rd_byte = mask_word_reg[7:0];
            default:     rd_byte = READ_UNMAPPED;
        endcase
    end

    assign shift_amt = STEPS_FULL - (steps_left_reg - 5'd1);

    always_comb begin
        data_word_next  = data_word_reg;
        mask_word_next  = mask_word_reg;
        shift_word_next = shift_word_reg;
        steps_left_next = steps_left_reg;
        mix_next        = mix_reg;
        bass_next       = bass_reg;
        treble_next     = treble_reg;
        master_next     = master_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        case (in_data_reg.req_type)
            REQ_WRITE: begin
                case (in_data_reg.reg_offset)
                    OFS_DATA_HI: data_word_next[15:8] = in_data_reg.write_data;
                    OFS_DATA_LO: begin
                        data_word_next[7:0] = in_data_reg.write_data;
                        if (steps_left_reg == 5'd0) begin
                            shift_word_next = {data_word_reg[15:8], in_data_reg.write_data};
                            steps_left_next = STEPS_FULL;
                        end
                    end
                    OFS_MASK_HI: mask_word_next[15:8] = in_data_reg.write_data;
                    OFS_MASK_LO: mask_word_next[7:0]  = in_data_reg.write_data;
                    default: ;
                endcase
            end
            REQ_TICK: begin
                if (steps_left_reg != 5'd0) begin
                    steps_left_next = steps_left_reg - 5'd1;
                    shift_word_next = 16'(data_word_reg << shift_amt);
                    // last step decodes the command
                    if (steps_left_reg == 5'd1 && cmd_ok) begin
                        case (cmd_sel)
                            SEL_MIX:    mix_next    = cmd_word[1:0];
                            SEL_BASS:   bass_next   = cmd_word[3:0];
                            SEL_TREBLE: treble_next = cmd_word[3:0];
                            SEL_MASTER: master_next = cmd_word[5:0];
                            SEL_RIGHT:  right_next  = cmd_word[4:0];
                            SEL_LEFT:   left_next   = cmd_word[4:0];
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            data_word_reg  <= '0;
            mask_word_reg  <= '0;
            shift_word_reg <= '0;
            steps_left_reg <= '0;
            mix_reg        <= MIX_RST;
            bass_reg       <= TONE_RST;
            treble_reg     <= TONE_RST;
            master_reg     <= MASTER_RST;
            left_reg       <= SIDE_RST;
            right_reg      <= SIDE_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                data_word_reg  <= data_word_next;
                mask_word_reg  <= mask_word_next;
                shift_word_reg <= shift_word_next;
                steps_left_reg <= steps_left_next;
                mix_reg        <= mix_next;
                bass_reg       <= bass_next;
                treble_reg     <= treble_next;
                master_reg     <= master_next;
                left_reg       <= left_next;
                right_reg      <= right_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg.read_data     <= (in_data_reg.req_type == REQ_READ) ? rd_byte : 8'd0;
            out_data_reg.busy_res      <= (steps_left_next != 5'd0);
            out_data_reg.mix_select    <= mix_next;
            out_data_reg.bass_code     <= bass_next;
            out_data_reg.treble_code   <= treble_next;
            out_data_reg.master_volume <= master_next;
            out_data_reg.left_volume   <= left_next;
            out_data_reg.right_volume  <= right_next;
        end
    end

    a_steps_range: assert property (@(posedge aclk) disable iff (!aresetn)
        steps_left_reg <= STEPS_FULL)
        else $error("transfer step count out of range");

    a_start_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.req_type == REQ_WRITE
        && in_data_reg.reg_offset == OFS_DATA_LO && steps_left_reg == 5'd0
        |=> steps_left_reg == STEPS_FULL && out_data_reg.busy_res)
        else $error("data low write did not start a transfer");

    a_last_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.req_type == REQ_TICK && steps_left_reg == 5'd1
        |=> steps_left_reg == 5'd0 && !out_data_reg.busy_res)
        else $error("last tick did not end the transfer");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |=> in_valid_reg && out_valid_reg)
        else $error("transaction lost while result stalled");

endmodule
